// ===== design/nnir_pkg.sv =====
// shared types and constants of the nearest-neighbor image scaler
// no dependencies; every other design file of the block but nnir_fifo refers to this one

package nnir_pkg;

  localparam int COORD_W    = 7;
  localparam int SIZE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int PROD_W     = COORD_W + SIZE_W;
  localparam int QUO_W      = 8;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH      = 3'd0,
    REG_SRC_HEIGHT     = 3'd1,
    REG_OUT_WIDTH      = 3'd2,
    REG_OUT_HEIGHT     = 3'd3,
    REG_THREE_CHANNELS = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_FETCH = 2'd1,
    KIND_OOR   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [SIZE_W-1:0] src_width;
    logic [SIZE_W-1:0] src_height;
    logic [SIZE_W-1:0] out_width;
    logic [SIZE_W-1:0] out_height;
    logic              three_channels;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } pixel_t;

  // one classified item waiting in the queue
  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PROD_W-1:0]  num_row;
    logic [PROD_W-1:0]  num_col;
    pixel_t             pixel;
  } entry_t;

  typedef struct packed {
    pixel_t pixel;
    logic   out_of_range;
  } result_t;

endpackage

// ===== design/nnir_cfg.sv =====
// configuration registers behind the apb-style port
// depends on nnir_pkg for the register map and the cfg_t type

module nnir_cfg #(
  parameter int MAX_SIDE = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nnir_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [nnir_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [nnir_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output nnir_pkg::cfg_t                   cfg
);

  localparam logic [nnir_pkg::SIZE_W-1:0] SIDE_CAP =
    (MAX_SIDE > 255) ? 8'd255 : nnir_pkg::SIZE_W'(MAX_SIDE);

  logic       wr_en;
  logic [2:0] reg_idx;

  function automatic logic [nnir_pkg::SIZE_W-1:0] clamp_side(
    input logic [nnir_pkg::SIZE_W-1:0] v
  );
    logic [nnir_pkg::SIZE_W-1:0] x;
    x = v;
    if (x == '0) x = 8'd1;
    if (x > SIDE_CAP) x = SIDE_CAP;
    return x;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[nnir_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width      <= 8'd1;
      cfg.src_height     <= 8'd1;
      cfg.out_width      <= 8'd1;
      cfg.out_height     <= 8'd1;
      cfg.three_channels <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        nnir_pkg::REG_SRC_WIDTH:      cfg.src_width      <= clamp_side(pwdata[7:0]);
        nnir_pkg::REG_SRC_HEIGHT:     cfg.src_height     <= clamp_side(pwdata[7:0]);
        nnir_pkg::REG_OUT_WIDTH:      cfg.out_width      <= clamp_side(pwdata[7:0]);
        nnir_pkg::REG_OUT_HEIGHT:     cfg.out_height     <= clamp_side(pwdata[7:0]);
        nnir_pkg::REG_THREE_CHANNELS: cfg.three_channels <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      nnir_pkg::REG_SRC_WIDTH:      prdata = {24'd0, cfg.src_width};
      nnir_pkg::REG_SRC_HEIGHT:     prdata = {24'd0, cfg.src_height};
      nnir_pkg::REG_OUT_WIDTH:      prdata = {24'd0, cfg.out_width};
      nnir_pkg::REG_OUT_HEIGHT:     prdata = {24'd0, cfg.out_height};
      nnir_pkg::REG_THREE_CHANNELS: prdata = {31'd0, cfg.three_channels};
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== design/nnir_fifo.sv =====
// small register-based fifo, used as the item queue and the result buffer
// no package dependency; payload is a plain vector

module nnir_fifo #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 4,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // depth is a power of two, so the pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/nnir_front.sv =====
// front end: takes items, sorts them into load, fetch and out-of-range,
// and forms the scaled numerators; depends on nnir_pkg

module nnir_front #(
  parameter int MAX_SIDE = 128
) (
  input  logic                               req_valid,
  input  logic                               command,
  input  logic [nnir_pkg::COORD_W-1:0]       row,
  input  logic [nnir_pkg::COORD_W-1:0]       col,
  input  logic [nnir_pkg::WORD_W-1:0]        sample_a,
  input  logic [nnir_pkg::WORD_W-1:0]        sample_b,
  input  logic [nnir_pkg::WORD_W-1:0]        sample_c,
  input  nnir_pkg::cfg_t                     cfg,
  input  logic                               queue_full,
  output logic                               req_stall,
  output logic                               push,
  output nnir_pkg::entry_t                   entry
);

  logic accept;
  logic load_in_store;
  logic fetch_oor;

  assign req_stall = queue_full;
  assign accept    = req_valid && !queue_full;

  always_comb begin
    load_in_store = (32'(row) < MAX_SIDE) && (32'(col) < MAX_SIDE);
    fetch_oor     = ({1'b0, row} >= cfg.out_height) || ({1'b0, col} >= cfg.out_width);

    entry.row     = row;
    entry.col     = col;
    entry.pixel.a = sample_a;
    entry.pixel.b = sample_b;
    entry.pixel.c = sample_c;
    entry.num_row = nnir_pkg::PROD_W'(row) * nnir_pkg::PROD_W'(cfg.src_height);
    entry.num_col = nnir_pkg::PROD_W'(col) * nnir_pkg::PROD_W'(cfg.src_width);

    // loads outside the store are dropped here
    if (command == nnir_pkg::CMD_LOAD) begin
      entry.kind = nnir_pkg::KIND_LOAD;
      push       = accept && load_in_store;
    end else if (fetch_oor) begin
      entry.kind = nnir_pkg::KIND_OOR;
      push       = accept;
    end else begin
      entry.kind = nnir_pkg::KIND_FETCH;
      push       = accept;
    end
  end

endmodule

// ===== design/nnir_back.sv =====
// back end: pipelined row/column dividers, source pixel store and read stage
// depends on nnir_pkg; results go to the output buffer under a credit check

module nnir_back #(
  parameter int MAX_SIDE  = 128,
  parameter int OUT_DEPTH = 8,
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  nnir_pkg::entry_t       head,
  input  nnir_pkg::cfg_t         cfg,
  input  logic [OUT_CNT_W-1:0]   out_count,
  output logic                   pop,
  output logic                   res_push,
  output nnir_pkg::result_t      res
);

  localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int AW         = $clog2(DEPTH);
  localparam int DIV_STAGES = 4;
  localparam int STEPS      = nnir_pkg::QUO_W / DIV_STAGES;
  localparam int LAST       = DIV_STAGES - 1;
  localparam int FLIGHT_W   = $clog2(DIV_STAGES + 2);

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] quo;
  } div_t;

  typedef struct packed {
    nnir_pkg::kind_t                kind;
    logic [nnir_pkg::COORD_W-1:0]   row;
    logic [nnir_pkg::COORD_W-1:0]   col;
    nnir_pkg::pixel_t               pixel;
    div_t                           dr;
    div_t                           dc;
  } stage_t;

  // quotient is known to fit 8 bits, so the top numerator bits start as remainder
  function automatic div_t div_start(input logic [nnir_pkg::PROD_W-1:0] num);
    div_t s;
    s.rem = {1'b0, num[14:8]};
    s.low = num[7:0];
    s.quo = '0;
    return s;
  endfunction

  function automatic div_t div_run(input div_t s_in, input logic [7:0] d);
    div_t       s;
    logic [8:0] r9;
    logic       q;
    s = s_in;
    for (int i = 0; i < STEPS; i++) begin
      r9 = {s.rem, s.low[7]};
      q  = 1'b0;
      s.low = {s.low[6:0], 1'b0};
      if (r9 >= {1'b0, d}) begin
        r9 = r9 - {1'b0, d};
        q  = 1'b1;
      end
      s.rem = r9[7:0];
      s.quo = {s.quo[6:0], q};
    end
    return s;
  endfunction

  function automatic logic [7:0] clamp_idx(input logic [7:0] q);
    logic [7:0] x;
    x = q;
    if (32'(q) >= MAX_SIDE) x = 8'(MAX_SIDE - 1);
    return x;
  endfunction

  stage_t                  st [DIV_STAGES];
  stage_t                  in0;
  logic [DIV_STAGES-1:0]   st_valid;
  logic [DIV_STAGES-1:0]   st_res;
  logic [FLIGHT_W-1:0]     inflight;
  logic [7:0]              srow;
  logic [7:0]              scol;
  logic [AW-1:0]           addr;
  logic                    last_load;
  logic                    last_fetch;
  nnir_pkg::pixel_t        mem [DEPTH];
  nnir_pkg::pixel_t        rd;
  logic                    m_valid;
  logic                    m_oor;

  // results still in flight plus results buffered must fit the output buffer
  assign inflight = FLIGHT_W'($countones(st_res)) + FLIGHT_W'(m_valid);
  assign pop      = head_valid && ((int'(out_count) + int'(inflight)) < OUT_DEPTH);

  always_comb begin
    in0.kind  = head.kind;
    in0.row   = head.row;
    in0.col   = head.col;
    in0.pixel = head.pixel;
    in0.dr    = div_run(div_start(head.num_row), cfg.out_height);
    in0.dc    = div_run(div_start(head.num_col), cfg.out_width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
      st_res   <= '0;
    end else begin
      st_valid <= {st_valid[DIV_STAGES-2:0], pop};
      st_res   <= {st_res[DIV_STAGES-2:0], pop && (head.kind != nnir_pkg::KIND_LOAD)};
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= in0;
    for (int s = 1; s < DIV_STAGES; s++) begin
      st[s].kind  <= st[s-1].kind;
      st[s].row   <= st[s-1].row;
      st[s].col   <= st[s-1].col;
      st[s].pixel <= st[s-1].pixel;
      st[s].dr    <= div_run(st[s-1].dr, cfg.out_height);
      st[s].dc    <= div_run(st[s-1].dc, cfg.out_width);
    end
  end

  always_comb begin
    srow       = clamp_idx(st[LAST].dr.quo);
    scol       = clamp_idx(st[LAST].dc.quo);
    last_load  = st_valid[LAST] && (st[LAST].kind == nnir_pkg::KIND_LOAD);
    last_fetch = st_valid[LAST] && (st[LAST].kind == nnir_pkg::KIND_FETCH);
    if (st[LAST].kind == nnir_pkg::KIND_LOAD) begin
      addr = AW'(st[LAST].row) * AW'(MAX_SIDE) + AW'(st[LAST].col);
    end else begin
      addr = AW'(srow) * AW'(MAX_SIDE) + AW'(scol);
    end
  end

  // loads write and fetches read at the same stage, so item order is kept
  always_ff @(posedge clk) begin
    if (last_load) begin
      mem[addr] <= st[LAST].pixel;
    end
    if (last_fetch) begin
      rd <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      m_oor   <= 1'b0;
    end else begin
      m_valid <= st_res[LAST];
      m_oor   <= st[LAST].kind == nnir_pkg::KIND_OOR;
    end
  end

  always_comb begin
    res_push           = m_valid;
    res.out_of_range   = m_oor;
    res.pixel.a        = m_oor ? '0 : rd.a;
    res.pixel.b        = (m_oor || !cfg.three_channels) ? '0 : rd.b;
    res.pixel.c        = (m_oor || !cfg.three_channels) ? '0 : rd.c;
  end

endmodule

// ===== design/nearest_neighbour_image_resize_core.sv =====
// nearest-neighbor image scaler, top level
// depends on nnir_pkg, nnir_cfg, nnir_front, nnir_fifo and nnir_back
//
// usage: program src_width, src_height, out_width, out_height and
// three_channels over the apb port while no item is in flight. items come in
// on req_valid/req_stall; a load (command 0) writes one source pixel at
// (row, col) and gives no result, a fetch (command 1) gives one result on
// rsp_valid/rsp_stall with the source pixel that the output (row, col) maps to,
// or out_of_range set and zero words when the coordinates lie outside.
// throughput is one item per cycle while nothing stalls; once its item is accepted,
// a fetch result passes the item queue, the four pipelined row and column divider
// stages (two quotient bits each), the store read and the result buffer.
// a stalled receiver fills the result buffer; the back end stops pulling from
// the item queue once buffered plus in-flight results reach the buffer depth,
// and req_stall rises when the item queue is full. reset sets all sizes to 1,
// one-channel mode and empty queues; the pixel store keeps no reset value.

module nearest_neighbour_image_resize_core #(
  parameter int MAX_SIDE    = 128,
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nnir_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [nnir_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [nnir_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             command,
  input  logic [nnir_pkg::COORD_W-1:0]     row,
  input  logic [nnir_pkg::COORD_W-1:0]     col,
  input  logic [nnir_pkg::WORD_W-1:0]      sample_a,
  input  logic [nnir_pkg::WORD_W-1:0]      sample_b,
  input  logic [nnir_pkg::WORD_W-1:0]      sample_c,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [nnir_pkg::WORD_W-1:0]      pixel_a,
  output logic [nnir_pkg::WORD_W-1:0]      pixel_b,
  output logic [nnir_pkg::WORD_W-1:0]      pixel_c,
  output logic                             out_of_range
);

  localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int ENTRY_W   = $bits(nnir_pkg::entry_t);
  localparam int RES_W     = $bits(nnir_pkg::result_t);

  nnir_pkg::cfg_t      cfg;
  nnir_pkg::entry_t    q_entry;
  nnir_pkg::entry_t    q_head;
  nnir_pkg::result_t   res;
  nnir_pkg::result_t   out_head;
  logic                q_push;
  logic                q_pop;
  logic                queue_full;
  logic [Q_CNT_W-1:0]  q_count;
  logic                res_push;
  logic                out_pop;
  logic [OUT_CNT_W-1:0] out_count;

  assign queue_full   = q_count == Q_CNT_W'(QUEUE_DEPTH);
  assign rsp_valid    = out_count != '0;
  assign out_pop      = rsp_valid && !rsp_stall;
  assign pixel_a      = out_head.pixel.a;
  assign pixel_b      = out_head.pixel.b;
  assign pixel_c      = out_head.pixel.c;
  assign out_of_range = out_head.out_of_range;

  nnir_cfg #(
    .MAX_SIDE (MAX_SIDE)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nnir_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .req_valid  (req_valid),
    .command    (command),
    .row        (row),
    .col        (col),
    .sample_a   (sample_a),
    .sample_b   (sample_b),
    .sample_c   (sample_c),
    .cfg        (cfg),
    .queue_full (queue_full),
    .req_stall  (req_stall),
    .push       (q_push),
    .entry      (q_entry)
  );

  nnir_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .pop_data  (q_head),
    .count     (q_count)
  );

  nnir_back #(
    .MAX_SIDE  (MAX_SIDE),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_count != '0),
    .head       (q_head),
    .cfg        (cfg),
    .out_count  (out_count),
    .pop        (q_pop),
    .res_push   (res_push),
    .res        (res)
  );

  nnir_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .pop       (out_pop),
    .pop_data  (out_head),
    .count     (out_count)
  );

endmodule

// ===== sim/nearest_neighbour_image_resize_core_test.sv =====
// self-checking testbench for nearest_neighbour_image_resize_core: directed table, then random
// load/fetch streams over many size settings with random idling on both item channels
// depends on nnir_pkg and the core; drives the apb port, the item port and the result port

module nearest_neighbour_image_resize_core_test;

  localparam int SIDE           = 128;
  localparam int ITEM_TARGET    = 1850;
  localparam int DRAIN_CYCLES   = 12;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PLAN_LEN       = 25;
  localparam logic TYPED        = 1'b1;
  localparam logic PREDICTED    = 1'b0;
  localparam nnir_pkg::pixel_t NO_WORDS   = '0;
  localparam nnir_pkg::result_t NO_RESULT = '0;
  localparam nnir_pkg::result_t OOR       = {96'h0, 1'b1};

  typedef enum logic {
    STEP_ITEM,
    STEP_WRITE
  } step_kind_t;

  typedef struct packed {
    step_kind_t                   kind;
    nnir_pkg::cmd_t               cmd;
    logic [nnir_pkg::COORD_W-1:0] r;
    logic [nnir_pkg::COORD_W-1:0] c;
    nnir_pkg::pixel_t             words;
    nnir_pkg::reg_idx_t           regi;
    logic [31:0]                  value;
    logic                         typed;
    nnir_pkg::result_t            given;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [nnir_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [nnir_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [nnir_pkg::APB_DATA_W-1:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_stall;
  logic command = 1'b0;
  logic [nnir_pkg::COORD_W-1:0] row = '0;
  logic [nnir_pkg::COORD_W-1:0] col = '0;
  logic [nnir_pkg::WORD_W-1:0] sample_a = '0;
  logic [nnir_pkg::WORD_W-1:0] sample_b = '0;
  logic [nnir_pkg::WORD_W-1:0] sample_c = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [nnir_pkg::WORD_W-1:0] pixel_a;
  logic [nnir_pkg::WORD_W-1:0] pixel_b;
  logic [nnir_pkg::WORD_W-1:0] pixel_c;
  logic out_of_range;

  nearest_neighbour_image_resize_core uut (.*);

  always #1 clk = ~clk;

  // shadow of the source image and of the size registers
  nnir_pkg::pixel_t source_image [SIDE*SIDE];
  bit loaded [SIDE*SIDE];
  logic [nnir_pkg::SIZE_W-1:0] src_w = 8'd1;
  logic [nnir_pkg::SIZE_W-1:0] src_h = 8'd1;
  logic [nnir_pkg::SIZE_W-1:0] out_w = 8'd1;
  logic [nnir_pkg::SIZE_W-1:0] out_h = 8'd1;
  logic three_ch = 1'b0;

  nnir_pkg::result_t awaited_pixels [$];
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int settings = 0;
  int squeeze_requests = 0;
  int squeeze_seen = 0;
  int hold_left = 0;
  int quiet = 0;
  logic calm = 1'b0;

  step_t plan [PLAN_LEN] = '{
    '{STEP_ITEM, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, {32'hFFFF_FFFF, 32'h0, 32'hAAAA_AAAA},
      nnir_pkg::REG_SRC_WIDTH, 32'd0, PREDICTED, NO_RESULT},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, TYPED, {32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0}},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd0, 7'd1, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, TYPED, OOR},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd1, 7'd0, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, TYPED, OOR},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd127, 7'd127, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, TYPED, OOR},
    // stored although it lies outside the 1x1 source
    '{STEP_ITEM, nnir_pkg::CMD_LOAD, 7'd127, 7'd127,
      {32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F},
      nnir_pkg::REG_SRC_WIDTH, 32'd0, PREDICTED, NO_RESULT},
    // words loaded in one-channel mode must come back in three-channel mode
    '{STEP_WRITE, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_THREE_CHANNELS, 32'd1, PREDICTED, NO_RESULT},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, TYPED, {32'hFFFF_FFFF, 32'h0, 32'hAAAA_AAAA, 1'b0}},
    '{STEP_WRITE, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd255, PREDICTED, NO_RESULT},
    '{STEP_WRITE, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_SRC_HEIGHT, 32'd128, PREDICTED, NO_RESULT},
    '{STEP_WRITE, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_OUT_WIDTH, 32'd128, PREDICTED, NO_RESULT},
    '{STEP_WRITE, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_OUT_HEIGHT, 32'd0, PREDICTED, NO_RESULT},
    '{STEP_ITEM, nnir_pkg::CMD_LOAD, 7'd0, 7'd127,
      {32'h5A5A_5A5A, 32'hC3C3_C3C3, 32'h0123_4567},
      nnir_pkg::REG_SRC_WIDTH, 32'd0, PREDICTED, NO_RESULT},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd0, 7'd127, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, PREDICTED, NO_RESULT},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd1, 7'd0, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, TYPED, OOR},
    // only the low byte counts
    '{STEP_WRITE, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_OUT_HEIGHT, 32'h180, PREDICTED, NO_RESULT},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd127, 7'd127, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, TYPED,
      {32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0}},
    '{STEP_WRITE, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd1, PREDICTED, NO_RESULT},
    '{STEP_WRITE, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_SRC_HEIGHT, 32'd1, PREDICTED, NO_RESULT},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd127, 7'd127, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, TYPED, {32'hFFFF_FFFF, 32'h0, 32'hAAAA_AAAA, 1'b0}},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd64, 7'd3, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, PREDICTED, NO_RESULT},
    // load then fetch of the same pixel back to back
    '{STEP_ITEM, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, {32'h0, 32'hFFFF_FFFF, 32'h5555_5555},
      nnir_pkg::REG_SRC_WIDTH, 32'd0, PREDICTED, NO_RESULT},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, TYPED, {32'h0, 32'hFFFF_FFFF, 32'h5555_5555, 1'b0}},
    '{STEP_WRITE, nnir_pkg::CMD_LOAD, 7'd0, 7'd0, NO_WORDS,
      nnir_pkg::REG_THREE_CHANNELS, 32'hFFFF_FFFE, PREDICTED, NO_RESULT},
    '{STEP_ITEM, nnir_pkg::CMD_FETCH, 7'd100, 7'd100, NO_WORDS,
      nnir_pkg::REG_SRC_WIDTH, 32'd0, TYPED, {32'h0, 32'h0, 32'h0, 1'b0}}
  };

  function automatic logic [nnir_pkg::SIZE_W-1:0] clamp_side(logic [31:0] v);
    logic [nnir_pkg::SIZE_W-1:0] x;
    x = v[7:0];
    if (x == 0) x = 8'd1;
    else if (x > SIDE) x = 8'(SIDE);
    return x;
  endfunction

  // store address of the source pixel that an output pixel maps to
  function automatic int source_addr(logic [nnir_pkg::COORD_W-1:0] orow,
                                     logic [nnir_pkg::COORD_W-1:0] ocol);
    int srow, scol;
    srow = int'(orow) * int'(src_h) / int'(out_h);
    scol = int'(ocol) * int'(src_w) / int'(out_w);
    return srow * SIDE + scol;
  endfunction

  function automatic nnir_pkg::result_t resized_pixel(logic [nnir_pkg::COORD_W-1:0] orow,
                                                      logic [nnir_pkg::COORD_W-1:0] ocol);
    nnir_pkg::result_t res;
    nnir_pkg::pixel_t px;
    res = '0;
    if (orow >= out_h || ocol >= out_w) begin
      res.out_of_range = 1'b1;
    end else begin
      px = source_image[source_addr(orow, ocol)];
      res.pixel.a = px.a;
      if (three_ch) begin
        res.pixel.b = px.b;
        res.pixel.c = px.c;
      end
    end
    return res;
  endfunction

  function automatic void check_word(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic nnir_pkg::pixel_t rand_pixel();
    return {rand_word(), rand_word(), rand_word()};
  endfunction

  function automatic logic [31:0] pick_side();
    case ($urandom_range(0, 15))
      0: return 32'd128;
      1: return 32'd0;
      2: return $urandom_range(129, 255);
      3: return $urandom();
      4, 5: return $urandom_range(13, 128);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup then access; psel stays high so a second transfer can follow directly
  task automatic apb_access(logic wr, nnir_pkg::reg_idx_t idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  task automatic write_reg(nnir_pkg::reg_idx_t idx, logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] held;
    wait_drained();
    apb_access(1'b1, idx, value, readback);
    case (idx)
      nnir_pkg::REG_SRC_WIDTH: begin
        src_w = clamp_side(value);
        held = {24'b0, src_w};
      end
      nnir_pkg::REG_SRC_HEIGHT: begin
        src_h = clamp_side(value);
        held = {24'b0, src_h};
      end
      nnir_pkg::REG_OUT_WIDTH: begin
        out_w = clamp_side(value);
        held = {24'b0, out_w};
      end
      nnir_pkg::REG_OUT_HEIGHT: begin
        out_h = clamp_side(value);
        held = {24'b0, out_h};
      end
      nnir_pkg::REG_THREE_CHANNELS: begin
        three_ch = value[0];
        held = {31'b0, three_ch};
      end
      default: held = '0;
    endcase
    apb_access(1'b0, idx, 32'b0, readback);
    psel <= 1'b0;
    penable <= 1'b0;
    check_word("prdata", held, readback);
    reg_writes++;
  endtask

  task automatic send_item(nnir_pkg::cmd_t cmd, logic [nnir_pkg::COORD_W-1:0] r,
                           logic [nnir_pkg::COORD_W-1:0] c, nnir_pkg::pixel_t words,
                           logic typed, nnir_pkg::result_t given);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_valid <= 1'b1;
    command <= cmd;
    row <= r;
    col <= c;
    sample_a <= words.a;
    sample_b <= words.b;
    sample_c <= words.c;
    do @(posedge clk); while (req_stall !== 1'b0);
    items_sent++;
    if (cmd == nnir_pkg::CMD_LOAD) begin
      source_image[int'(r) * SIDE + int'(c)] = words;
      loaded[int'(r) * SIDE + int'(c)] = 1'b1;
    end else begin
      awaited_pixels.push_back(typed ? given : resized_pixel(r, c));
    end
  endtask

  // a fetch that maps onto a pixel never loaded gets that pixel loaded first
  task automatic fetch_pixel(logic [nnir_pkg::COORD_W-1:0] r,
                             logic [nnir_pkg::COORD_W-1:0] c);
    int addr;
    if (r < out_h && c < out_w) begin
      addr = source_addr(r, c);
      if (!loaded[addr])
        send_item(nnir_pkg::CMD_LOAD, 7'(addr / SIDE), 7'(addr % SIDE), rand_pixel(),
                  PREDICTED, NO_RESULT);
    end
    send_item(nnir_pkg::CMD_FETCH, r, c, rand_pixel(), PREDICTED, NO_RESULT);
  endtask

  always @(posedge clk) begin
    nnir_pkg::result_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (awaited_pixels.size() == 0) begin
        $error("result item with no fetch waiting for it");
        mismatches++;
      end else begin
        want = awaited_pixels.pop_front();
        check_word("pixel_a", want.pixel.a, pixel_a);
        check_word("pixel_b", want.pixel.b, pixel_b);
        check_word("pixel_c", want.pixel.c, pixel_c);
        check_word("out_of_range", 32'(want.out_of_range), 32'(out_of_range));
        results_checked++;
      end
    end
  end

  // result side stalls: random bursts, or one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (squeeze_seen != squeeze_requests) begin
      squeeze_seen <= squeeze_requests;
      hold_left <= SQUEEZE_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 16);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
        (psel && penable && pready === 1'b1)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("nearest_neighbour_image_resize_core_test: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int pick;
    logic winding_down;
    logic squeeze;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE)
        write_reg(plan[i].regi, plan[i].value);
      else
        send_item(plan[i].cmd, plan[i].r, plan[i].c, plan[i].words, plan[i].typed,
                  plan[i].given);
    end

    while (items_sent < ITEM_TARGET) begin
      settings++;
      write_reg(nnir_pkg::REG_SRC_WIDTH, pick_side());
      write_reg(nnir_pkg::REG_SRC_HEIGHT, pick_side());
      write_reg(nnir_pkg::REG_OUT_WIDTH, pick_side());
      write_reg(nnir_pkg::REG_OUT_HEIGHT, pick_side());
      write_reg(nnir_pkg::REG_THREE_CHANNELS, $urandom());
      winding_down = items_sent >= ITEM_TARGET - 250;
      squeeze = !winding_down && (settings == 2 || $urandom_range(0, 11) == 0);
      calm = winding_down || squeeze || $urandom_range(0, 3) == 0;
      // receiver holds off while items keep coming, so the queues fill up
      if (squeeze) squeeze_requests++;
      repeat ($urandom_range(30, 100)) begin
        pick = $urandom_range(0, 99);
        if (pick < 25)
          send_item(nnir_pkg::CMD_LOAD, 7'($urandom_range(0, src_h - 1)),
                    7'($urandom_range(0, src_w - 1)), rand_pixel(), PREDICTED, NO_RESULT);
        else if (pick < 80)
          fetch_pixel(7'($urandom_range(0, out_h - 1)), 7'($urandom_range(0, out_w - 1)));
        else if (pick < 90)
          fetch_pixel(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        else
          send_item(nnir_pkg::CMD_LOAD, 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 127)), rand_pixel(), PREDICTED, NO_RESULT);
      end
    end

    wait_drained();
    $display("sent %0d load/fetch items and checked %0d fetch results over %0d size settings",
             items_sent, results_checked, settings);
    $display("%0d register writes, each read back, with clamped and oversized values",
             reg_writes);
    if (mismatches == 0)
      $display("nearest_neighbour_image_resize_core_test: clean");
    else
      $display("nearest_neighbour_image_resize_core_test: errors");
    $finish;
  end

endmodule
